[sv/arp_resolver_with_cache_core_defines.svh]
// ----------------------------------------------------------------------------
// ARP resolver assertion macros
// Clocked assertion wrappers; empty when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef ARP_RESOLVER_WITH_CACHE_CORE_DEFINES_SVH
`define ARP_RESOLVER_WITH_CACHE_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define ARP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ARP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ARP_ASSERT(lbl, prop, msg)
`define ARP_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[sv/arp_pkg.sv]
// ----------------------------------------------------------------------------
// ARP resolver package
// Sizes, codes and shared types of the ARP resolver.
// ----------------------------------------------------------------------------
package arp_pkg;

    localparam int CACHE_ENTRIES   = 16;
    localparam int PENDING_ENTRIES = 8;
    localparam int QUEUE_DEPTH     = 16;

    localparam int CACHE_AW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int PEND_AW  = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;
    localparam int QAW      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);
    // queue entries sit low, pending marks above them in the same memory
    localparam int PQ_DEPTH = QUEUE_DEPTH + PENDING_ENTRIES;
    localparam int PQ_AW    = $clog2(PQ_DEPTH);
    localparam int SCAN_MAX = (CACHE_ENTRIES > QUEUE_DEPTH) ?
        ((CACHE_ENTRIES > PENDING_ENTRIES) ? CACHE_ENTRIES : PENDING_ENTRIES) :
        ((QUEUE_DEPTH > PENDING_ENTRIES) ? QUEUE_DEPTH : PENDING_ENTRIES);
    localparam int SCAN_W   = $clog2(SCAN_MAX + 1);

    localparam logic [15:0] LIFETIME_RESET = 16'd30000;
    localparam logic [15:0] HOLDOFF_RESET  = 16'd5000;
    localparam logic [15:0] ETH_IPV4       = 16'h0800;
    localparam logic [15:0] ETH_ARP        = 16'h0806;
    localparam logic [15:0] ARP_OP_REQUEST = 16'd1;
    localparam logic [47:0] MAC_BCAST      = 48'hFFFF_FFFF_FFFF;

    typedef enum logic [1:0] {OP_SEND, OP_RECV, OP_TICK, OP_NONE} op_t;
    typedef enum logic [1:0] {KIND_IPV4, KIND_ARP_REQ, KIND_ARP_REPLY, KIND_DELIVER} kind_t;
    typedef enum logic [1:0] {CFG_OWN_MAC, CFG_OWN_IP, CFG_LIFETIME, CFG_HOLDOFF} cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CSCAN, ST_PSCAN, ST_SEND_REQ, ST_PMARK, ST_CLEARN, ST_QSCAN,
        ST_REPLY, ST_HIT, ST_DELIVER, ST_CTICK, ST_PTICK, ST_FLUSH
    } st_t;

    typedef struct packed {
        logic [47:0] own_mac;
        logic [31:0] own_ip;
        logic [15:0] lifetime;
        logic [15:0] holdoff;
    } cfg_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] hop_ip;
        logic [15:0] datagram_tag;
        logic [47:0] frame_dst_mac;
        logic [15:0] frame_type;
        logic        payload_ok;
        logic [15:0] arp_opcode;
        logic [47:0] arp_sender_mac;
        logic [31:0] arp_sender_ip;
        logic [31:0] arp_target_ip_in;
        logic [15:0] elapsed_ms;
    } item_t;

    typedef struct packed {
        kind_t       kind;
        logic [47:0] dest_mac;
        logic [31:0] arp_target_ip_out;
        logic [47:0] arp_target_mac_out;
        logic [15:0] tag_out;
    } res_t;

    typedef struct packed {
        logic [31:0] ip;
        logic [47:0] mac;
        logic [15:0] age;
    } cache_ent_t;

    // queue: hop and tag; pending: ip and age
    typedef struct packed {
        logic [31:0] key;
        logic [15:0] val;
    } pq_ent_t;

    typedef struct packed {
        logic push;
        logic flush;
        res_t res;
    } em_ctl_t;

    typedef struct packed {
        logic push_ok;
        logic flush_done;
    } em_sts_t;

endpackage

[sv/arp_ram.sv]
// ----------------------------------------------------------------------------
// ARP generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module arp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/arp_emit.sv]
// ----------------------------------------------------------------------------
// ARP result emitter
// Holds one result back so the final one of an item can be marked last.
// ----------------------------------------------------------------------------
module arp_emit import arp_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  em_ctl_t ctl,
    output em_sts_t sts,
    output logic    out_valid,
    input  logic    out_ready,
    output res_t    out_res,
    output logic    out_last
);

    logic hold_vld_reg;
    res_t hold_reg;
    logic out_vld_reg;
    res_t out_reg;
    logic out_last_reg;
    logic out_free;
    logic take;
    logic drain;

    assign out_free = !out_vld_reg || out_ready;
    assign take     = ctl.push && (!hold_vld_reg || out_free);
    assign drain    = !ctl.push && ctl.flush && hold_vld_reg && out_free;

    assign sts.push_ok    = !hold_vld_reg || out_free;
    assign sts.flush_done = !hold_vld_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                hold_vld_reg <= 1'b1;
            end
            else if (drain)
            begin
                hold_vld_reg <= 1'b0;
            end
            if ((take && hold_vld_reg) || drain)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            hold_reg <= ctl.res;
        end
        if ((take && hold_vld_reg) || drain)
        begin
            out_reg      <= hold_reg;
            out_last_reg <= drain;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_res   = out_reg;
    assign out_last  = out_last_reg;

endmodule

[sv/arp_ctrl.sv]
// ----------------------------------------------------------------------------
// ARP sequencer
// Walks the cache and the queue/pending memory one entry a cycle per request, pausing queue walks on a full emitter.
// ----------------------------------------------------------------------------
`include "arp_resolver_with_cache_core_defines.svh"
module arp_ctrl import arp_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    in_valid,
    output logic    in_ready,
    input  item_t   item,
    output em_ctl_t em_ctl,
    input  em_sts_t em_sts
);

    st_t                        state_reg, state_next;
    item_t                      item_reg, item_next;
    logic [SCAN_W-1:0]          cnt_reg, cnt_next;
    logic [SCAN_W-1:0]          ridx_reg, ridx_next;
    logic                       rvld_reg, rvld_next;
    logic [CACHE_ENTRIES-1:0]   cvalid_reg, cvalid_next;
    logic [PENDING_ENTRIES-1:0] pvalid_reg, pvalid_next;
    logic [QCNT_W-1:0]          qcount_reg, qcount_next;
    logic [QCNT_W-1:0]          keep_reg, keep_next;
    logic                       hit_reg, hit_next;
    logic [SCAN_W-1:0]          hit_idx_reg, hit_idx_next;
    logic [47:0]                hit_mac_reg, hit_mac_next;
    logic                       old_set_reg, old_set_next;
    logic [SCAN_W-1:0]          old_idx_reg, old_idx_next;
    logic [15:0]                old_age_reg, old_age_next;

    logic                c_we, c_re;
    logic [CACHE_AW-1:0] c_waddr, c_raddr;
    cache_ent_t          c_wdata, c_rdata;
    logic                p_we, p_re;
    logic [PQ_AW-1:0]    p_waddr, p_raddr;
    pq_ent_t             p_wdata, p_rdata;

    logic [SCAN_W-1:0]   scan_lim;
    logic [CACHE_AW-1:0] ci;
    logic [PEND_AW-1:0]  pi;
    logic [31:0]         key;
    logic                q_rel;
    logic                stall;
    logic                issue;
    logic                scan_done;
    logic                reply_cond;
    logic                for_us;
    logic                c_free_ok;
    logic [CACHE_AW-1:0] c_free_idx;
    logic                p_free_ok;
    logic [PEND_AW-1:0]  p_free_idx;
    logic [CACHE_AW-1:0] c_pick;
    logic [PEND_AW-1:0]  p_pick;
    logic [16:0]         age_sum;

    arp_ram #(.WIDTH($bits(cache_ent_t)), .DEPTH(CACHE_ENTRIES)) u_cache_ram (
        .clk   (clk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata (c_wdata),
        .re    (c_re),
        .raddr (c_raddr),
        .rdata (c_rdata)
    );

    arp_ram #(.WIDTH($bits(pq_ent_t)), .DEPTH(PQ_DEPTH)) u_pq_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .re    (p_re),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    assign ci  = ridx_reg[CACHE_AW-1:0];
    assign pi  = ridx_reg[PEND_AW-1:0];
    assign key = (item_reg.op == OP_SEND) ? item_reg.hop_ip : item_reg.arp_sender_ip;

    always_comb
    begin
        case (state_reg)
            ST_CSCAN, ST_CTICK: scan_lim = SCAN_W'(CACHE_ENTRIES);
            ST_PSCAN, ST_PTICK: scan_lim = SCAN_W'(PENDING_ENTRIES);
            ST_QSCAN:           scan_lim = SCAN_W'(qcount_reg);
            default:            scan_lim = '0;
        endcase
    end

    // a queued hop can only resolve to the address just learned
    assign q_rel      = (state_reg == ST_QSCAN) && rvld_reg &&
                        (p_rdata.key == item_reg.arp_sender_ip);
    assign stall      = q_rel && !em_sts.push_ok;
    assign issue      = (cnt_reg < scan_lim) && !stall;
    assign scan_done  = (cnt_reg >= scan_lim) && !rvld_reg;
    assign reply_cond = (item_reg.arp_opcode == ARP_OP_REQUEST) &&
                        (item_reg.arp_target_ip_in == cfg.own_ip);
    assign for_us     = (item.frame_dst_mac == MAC_BCAST) || (item.frame_dst_mac == cfg.own_mac);

    always_comb
    begin
        c_free_ok  = 1'b0;
        c_free_idx = '0;
        for (int i = CACHE_ENTRIES - 1; i >= 0; i--)
        begin
            if (!cvalid_reg[i])
            begin
                c_free_ok  = 1'b1;
                c_free_idx = CACHE_AW'(i);
            end
        end
        p_free_ok  = 1'b0;
        p_free_idx = '0;
        for (int i = PENDING_ENTRIES - 1; i >= 0; i--)
        begin
            if (!pvalid_reg[i])
            begin
                p_free_ok  = 1'b1;
                p_free_idx = PEND_AW'(i);
            end
        end
    end

    assign c_pick = hit_reg ? hit_idx_reg[CACHE_AW-1:0] :
                    (c_free_ok ? c_free_idx : old_idx_reg[CACHE_AW-1:0]);
    assign p_pick = p_free_ok ? p_free_idx : old_idx_reg[PEND_AW-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (item.op)
                        OP_SEND: state_next = ST_CSCAN;
                        OP_RECV:
                        begin
                            if (for_us && item.payload_ok && item.frame_type == ETH_IPV4)
                                state_next = ST_DELIVER;
                            else if (for_us && item.payload_ok && item.frame_type == ETH_ARP)
                                state_next = ST_CSCAN;
                        end
                        OP_TICK: state_next = ST_CTICK;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CSCAN:
            begin
                if (scan_done)
                begin
                    if (item_reg.op != OP_SEND)
                        state_next = ST_CLEARN;
                    else if (hit_reg)
                        state_next = ST_HIT;
                    else
                        state_next = ST_PSCAN;
                end
            end
            ST_PSCAN:
            begin
                if (scan_done)
                    state_next = hit_reg ? ST_FLUSH : ST_SEND_REQ;
            end
            ST_SEND_REQ:
            begin
                if (em_sts.push_ok)
                    state_next = ST_PMARK;
            end
            ST_PMARK:  state_next = ST_FLUSH;
            ST_CLEARN: state_next = ST_QSCAN;
            ST_QSCAN:
            begin
                if (scan_done)
                    state_next = reply_cond ? ST_REPLY : ST_FLUSH;
            end
            ST_REPLY, ST_HIT, ST_DELIVER:
            begin
                if (em_sts.push_ok)
                    state_next = ST_FLUSH;
            end
            ST_CTICK:
            begin
                if (scan_done)
                    state_next = ST_PTICK;
            end
            ST_PTICK:
            begin
                if (scan_done)
                    state_next = ST_FLUSH;
            end
            ST_FLUSH:
            begin
                if (em_sts.flush_done)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        item_next    = item_reg;
        cnt_next     = cnt_reg;
        ridx_next    = ridx_reg;
        rvld_next    = rvld_reg;
        cvalid_next  = cvalid_reg;
        pvalid_next  = pvalid_reg;
        qcount_next  = qcount_reg;
        keep_next    = keep_reg;
        hit_next     = hit_reg;
        hit_idx_next = hit_idx_reg;
        hit_mac_next = hit_mac_reg;
        old_set_next = old_set_reg;
        old_idx_next = old_idx_reg;
        old_age_next = old_age_reg;
        in_ready     = 1'b0;
        em_ctl       = '0;
        c_we         = 1'b0;
        c_re         = 1'b0;
        c_waddr      = ci;
        c_raddr      = cnt_reg[CACHE_AW-1:0];
        c_wdata      = c_rdata;
        p_we         = 1'b0;
        p_re         = 1'b0;
        p_waddr      = PQ_AW'(QUEUE_DEPTH) + PQ_AW'(pi);
        p_raddr      = PQ_AW'(QUEUE_DEPTH) + PQ_AW'(cnt_reg[PEND_AW-1:0]);
        p_wdata      = p_rdata;
        age_sum      = '0;

        if (issue)
        begin
            cnt_next  = cnt_reg + 1'b1;
            ridx_next = cnt_reg;
            rvld_next = 1'b1;
        end
        else if (!stall)
        begin
            rvld_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    item_next    = item;
                    cnt_next     = '0;
                    rvld_next    = 1'b0;
                    hit_next     = 1'b0;
                    old_set_next = 1'b0;
                end
            end
            ST_CSCAN:
            begin
                c_re = issue;
                if (rvld_reg && cvalid_reg[ci])
                begin
                    if (!hit_reg && c_rdata.ip == key)
                    begin
                        hit_next     = 1'b1;
                        hit_idx_next = ridx_reg;
                        hit_mac_next = c_rdata.mac;
                    end
                    if (!old_set_reg || c_rdata.age > old_age_reg)
                    begin
                        old_set_next = 1'b1;
                        old_idx_next = ridx_reg;
                        old_age_next = c_rdata.age;
                    end
                end
                if (scan_done && item_reg.op == OP_SEND)
                begin
                    cnt_next     = '0;
                    old_set_next = 1'b0;
                end
            end
            ST_PSCAN:
            begin
                p_re = issue;
                if (rvld_reg && pvalid_reg[pi])
                begin
                    if (p_rdata.key == item_reg.hop_ip)
                        hit_next = 1'b1;
                    if (!old_set_reg || p_rdata.val > old_age_reg)
                    begin
                        old_set_next = 1'b1;
                        old_idx_next = ridx_reg;
                        old_age_next = p_rdata.val;
                    end
                end
            end
            ST_SEND_REQ:
            begin
                em_ctl.push = 1'b1;
                em_ctl.res  = '{KIND_ARP_REQ, MAC_BCAST, item_reg.hop_ip, 48'd0, 16'd0};
                if (em_sts.push_ok && qcount_reg < QCNT_W'(QUEUE_DEPTH))
                begin
                    p_we        = 1'b1;
                    p_waddr     = PQ_AW'(qcount_reg[QAW-1:0]);
                    p_wdata     = '{item_reg.hop_ip, item_reg.datagram_tag};
                    qcount_next = qcount_reg + 1'b1;
                end
            end
            ST_PMARK:
            begin
                p_we                = 1'b1;
                p_waddr             = PQ_AW'(QUEUE_DEPTH) + PQ_AW'(p_pick);
                p_wdata             = '{item_reg.hop_ip, 16'd0};
                pvalid_next[p_pick] = 1'b1;
            end
            ST_CLEARN:
            begin
                c_we                = 1'b1;
                c_waddr             = c_pick;
                c_wdata             = '{item_reg.arp_sender_ip, item_reg.arp_sender_mac, 16'd0};
                cvalid_next[c_pick] = 1'b1;
                cnt_next            = '0;
                keep_next           = '0;
            end
            ST_QSCAN:
            begin
                p_re    = issue;
                p_raddr = PQ_AW'(cnt_reg[QAW-1:0]);
                if (q_rel)
                begin
                    em_ctl.push = 1'b1;
                    em_ctl.res  = '{KIND_IPV4, item_reg.arp_sender_mac, 32'd0, 48'd0,
                                    p_rdata.val};
                end
                else if (rvld_reg)
                begin
                    // compact the unresolved ones towards the head
                    p_we      = 1'b1;
                    p_waddr   = PQ_AW'(keep_reg[QAW-1:0]);
                    p_wdata   = p_rdata;
                    keep_next = keep_reg + 1'b1;
                end
                if (scan_done)
                    qcount_next = keep_reg;
            end
            ST_REPLY:
            begin
                em_ctl.push = 1'b1;
                em_ctl.res  = '{KIND_ARP_REPLY, item_reg.arp_sender_mac, item_reg.arp_sender_ip,
                                item_reg.arp_sender_mac, 16'd0};
            end
            ST_HIT:
            begin
                em_ctl.push = 1'b1;
                em_ctl.res  = '{KIND_IPV4, hit_mac_reg, 32'd0, 48'd0, item_reg.datagram_tag};
            end
            ST_DELIVER:
            begin
                em_ctl.push = 1'b1;
                em_ctl.res  = '{KIND_DELIVER, 48'd0, 32'd0, 48'd0, item_reg.datagram_tag};
            end
            ST_CTICK:
            begin
                c_re    = issue;
                age_sum = {1'b0, c_rdata.age} + {1'b0, item_reg.elapsed_ms};
                if (rvld_reg && cvalid_reg[ci])
                begin
                    if (age_sum >= {1'b0, cfg.lifetime})
                    begin
                        cvalid_next[ci] = 1'b0;
                    end
                    else
                    begin
                        c_we    = 1'b1;
                        c_wdata = '{c_rdata.ip, c_rdata.mac, age_sum[15:0]};
                    end
                end
                if (scan_done)
                    cnt_next = '0;
            end
            ST_PTICK:
            begin
                p_re    = issue;
                age_sum = {1'b0, p_rdata.val} + {1'b0, item_reg.elapsed_ms};
                if (rvld_reg && pvalid_reg[pi])
                begin
                    if (age_sum >= {1'b0, cfg.holdoff})
                    begin
                        pvalid_next[pi] = 1'b0;
                    end
                    else
                    begin
                        p_we    = 1'b1;
                        p_wdata = '{p_rdata.key, age_sum[15:0]};
                    end
                end
            end
            ST_FLUSH:
            begin
                em_ctl.flush = 1'b1;
            end
            default:
            begin
                em_ctl = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            rvld_reg    <= 1'b0;
            cvalid_reg  <= '0;
            pvalid_reg  <= '0;
            qcount_reg  <= '0;
            keep_reg    <= '0;
            hit_reg     <= 1'b0;
            old_set_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            rvld_reg    <= rvld_next;
            cvalid_reg  <= cvalid_next;
            pvalid_reg  <= pvalid_next;
            qcount_reg  <= qcount_next;
            keep_reg    <= keep_next;
            hit_reg     <= hit_next;
            old_set_reg <= old_set_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        ridx_reg    <= ridx_next;
        hit_idx_reg <= hit_idx_next;
        hit_mac_reg <= hit_mac_next;
        old_idx_reg <= old_idx_next;
        old_age_reg <= old_age_next;
    end

    `ARP_ASSERT(a_cache_rw_apart, (c_we && c_re) |-> (c_waddr != c_raddr), "cache read hits write")
    `ARP_ASSERT(a_pq_rw_apart, (p_we && p_re) |-> (p_waddr != p_raddr), "queue read hits write")
    `ARP_ASSERT(a_qcount_max, qcount_reg <= QCNT_W'(QUEUE_DEPTH), "queue count overflow")
    `ARP_ASSERT(a_keep_behind, (state_reg == ST_QSCAN) |-> (SCAN_W'(keep_reg) <= cnt_reg), "compaction overtook read")

endmodule

[sv/arp_resolver_with_cache_core.sv]
// ----------------------------------------------------------------------------
// ARP resolver with cache
// Top level: stream ports, configuration registers, sequencer and emitter.
// ----------------------------------------------------------------------------
// One request is handled at a time; it walks the cache memory and the
// queue/pending memory one entry a cycle through their single read ports,
// a queue walk pausing while the emitter cannot take a result. A send walks
// the cache of 16 entries and, on a cache miss, the pending marks of 8; an
// ARP frame walks the cache and then the queue, and is answered when it asks
// for our address; a tick walks the cache and the pending marks; a delivered
// IPv4 frame and a dropped request walk nothing. Each result leaves through
// an output register; results wait while m_tready is low, and the next
// request is taken once the last result is registered.
module arp_resolver_with_cache_core import arp_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [47:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // hop_ip, datagram_tag, frame_dst_mac, frame_type, payload_ok, arp_opcode,
    // arp_sender_mac, arp_sender_ip, arp_target_ip_in, elapsed_ms, zero fill
    input  logic [263:0] s_tdata,
    input  logic [1:0]   s_tuser,   // op
    output logic         m_tvalid,
    input  logic         m_tready,
    // dest_mac, arp_target_ip_out, arp_target_mac_out, tag_out
    output logic [143:0] m_tdata,
    output logic [1:0]   m_tuser,   // kind
    output logic         m_tlast
);

    cfg_t    cfg_reg;
    item_t   item;
    em_ctl_t em_ctl;
    em_sts_t em_sts;
    res_t    out_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.own_mac  <= '0;
            cfg_reg.own_ip   <= '0;
            cfg_reg.lifetime <= LIFETIME_RESET;
            cfg_reg.holdoff  <= HOLDOFF_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_OWN_MAC:  cfg_reg.own_mac  <= cfg_wdata;
                CFG_OWN_IP:   cfg_reg.own_ip   <= cfg_wdata[31:0];
                CFG_LIFETIME: cfg_reg.lifetime <= cfg_wdata[15:0];
                CFG_HOLDOFF:  cfg_reg.holdoff  <= cfg_wdata[15:0];
                default:      cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign item.op               = op_t'(s_tuser);
    assign item.hop_ip           = s_tdata[31:0];
    assign item.datagram_tag     = s_tdata[47:32];
    assign item.frame_dst_mac    = s_tdata[95:48];
    assign item.frame_type       = s_tdata[111:96];
    assign item.payload_ok       = s_tdata[112];
    assign item.arp_opcode       = s_tdata[128:113];
    assign item.arp_sender_mac   = s_tdata[176:129];
    assign item.arp_sender_ip    = s_tdata[208:177];
    assign item.arp_target_ip_in = s_tdata[240:209];
    assign item.elapsed_ms       = s_tdata[256:241];

    arp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .item     (item),
        .em_ctl   (em_ctl),
        .em_sts   (em_sts)
    );

    arp_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (em_ctl),
        .sts       (em_sts),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res),
        .out_last  (m_tlast)
    );

    assign m_tuser = out_res.kind;
    assign m_tdata = {out_res.tag_out, out_res.arp_target_mac_out,
                      out_res.arp_target_ip_out, out_res.dest_mac};

endmodule
